@@ rtl/core/rpt_pkg.sv @@
// Shared types, constants and helpers for the radix page table walker.
package rpt_pkg;

  // Table geometry
  localparam int NUM_FRAMES        = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int LEVELS            = 5;
  localparam int INDEX_BITS        = 9;

  // Field widths
  localparam int VPN_W    = 45;
  localparam int PPN_W    = 52;
  localparam int ENTRY_W  = PPN_W + 1;
  localparam int FRAME_W  = $clog2(NUM_FRAMES);
  localparam int FREE_W   = $clog2(NUM_FRAMES + 1);
  localparam int TABLE_W  = $clog2(ENTRIES_PER_TABLE);
  localparam int DEPTH    = NUM_FRAMES * ENTRIES_PER_TABLE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int LEVEL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int IDX_MASK = (1 << INDEX_BITS) - 1;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int ROOT_W  = 6;
  localparam int FIRST_W = 7;

  localparam logic [ROOT_W-1:0]  ROOT_RESET  = ROOT_W'(0);
  localparam logic [FIRST_W-1:0] FIRST_RESET = FIRST_W'(1);

  typedef enum logic {
    REG_ROOT_FRAME = 1'b0,
    REG_FIRST_FREE = 1'b1
  } reg_idx_e;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             cmd;
    logic [VPN_W-1:0] vpn;
    logic [PPN_W-1:0] new_ppn;
    logic             unmap;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [PPN_W-1:0] ppn_out;
    logic             status;
  } out_item_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  root_frame;
    logic               ff_load;
    logic [FIRST_W-1:0] ff_value;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  // Table index of one level, most significant level first.
  function automatic logic [TABLE_W-1:0] level_index(input logic [VPN_W-1:0]   vpn,
                                                     input logic [LEVEL_W-1:0] level);
    logic [TABLE_W-1:0] idx;
    logic [VPN_W-1:0]   sh;
    idx = '0;
    sh  = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (level == LEVEL_W'(l)) begin
        sh  = vpn >> (INDEX_BITS * (LEVELS - 1 - l));
        idx = TABLE_W'(sh & VPN_W'(IDX_MASK));
      end
    end
    return idx;
  endfunction

endpackage

@@ rtl/core/rpt_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module rpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/core/rpt_regs.sv @@
// APB configuration registers of the page table walker.
module rpt_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpt_pkg::PADDR_W-1:0] paddr,
  input  logic [rpt_pkg::PDATA_W-1:0] pwdata,
  output logic [rpt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output rpt_pkg::cfg_t               cfg_o
);

  logic [rpt_pkg::ROOT_W-1:0]  root_q, root_d;
  logic [rpt_pkg::FIRST_W-1:0] first_q, first_d;
  logic                        wr_en;
  rpt_pkg::reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = rpt_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    root_d  = root_q;
    first_d = first_q;
    if (wr_en) begin
      unique case (idx)
        rpt_pkg::REG_ROOT_FRAME: root_d  = pwdata[rpt_pkg::ROOT_W-1:0];
        rpt_pkg::REG_FIRST_FREE: first_d = pwdata[rpt_pkg::FIRST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      rpt_pkg::REG_ROOT_FRAME: prdata = rpt_pkg::PDATA_W'(root_q);
      rpt_pkg::REG_FIRST_FREE: prdata = rpt_pkg::PDATA_W'(first_q);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= rpt_pkg::ROOT_RESET;
      first_q <= rpt_pkg::FIRST_RESET;
    end else begin
      root_q  <= root_d;
      first_q <= first_d;
    end
  end

  assign cfg_o.root_frame = root_q;
  assign cfg_o.ff_load    = wr_en && (idx == rpt_pkg::REG_FIRST_FREE);
  assign cfg_o.ff_value   = pwdata[rpt_pkg::FIRST_W-1:0];

endmodule

@@ rtl/core/rpt_walk.sv @@
// Walk sequencer: memory clear, per-level read/evaluate/write, frame allocator.
module rpt_walk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rpt_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rpt_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rpt_pkg::out_item_t          out_item_o,
  output rpt_pkg::mem_req_t           mem_req_o,
  input  logic [rpt_pkg::ENTRY_W-1:0] mem_rdata_i
);

  rpt_pkg::state_e state_q, state_d;

  logic [rpt_pkg::ADDR_W-1:0]  clr_q, clr_d;
  rpt_pkg::in_item_t           item_q, item_d;
  logic [rpt_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [rpt_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic [rpt_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [rpt_pkg::FREE_W-1:0]  free_q, free_d;
  rpt_pkg::out_item_t          res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  rpt_pkg::out_item_t          out_q, out_d;

  logic                        in_acc, out_free, clr_last;
  logic                        ev_done, ev_we, ev_alloc;
  logic [rpt_pkg::ENTRY_W-1:0] ev_wdata;
  logic [rpt_pkg::FRAME_W-1:0] ev_frame;
  rpt_pkg::out_item_t          ev_res;
  logic                        e_valid, leaf;
  logic [rpt_pkg::ADDR_W-1:0]  rd_addr;

  assign in_stall_o = (state_q != rpt_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clr_last   = (clr_q == rpt_pkg::ADDR_W'(rpt_pkg::DEPTH - 1));
  assign rd_addr    = {frame_q, rpt_pkg::level_index(item_q.vpn, level_q)};

  assign e_valid = mem_rdata_i[0];
  assign leaf    = (level_q == rpt_pkg::LEVEL_W'(rpt_pkg::LEVELS - 1));

  // Decode the entry just read
  always_comb begin
    ev_done  = 1'b0;
    ev_we    = 1'b0;
    ev_alloc = 1'b0;
    ev_wdata = '0;
    ev_frame = mem_rdata_i[rpt_pkg::FRAME_W:1];
    ev_res   = res_q;
    if (item_q.cmd == rpt_pkg::CMD_QUERY) begin
      if (!e_valid) begin
        ev_done = 1'b1;
      end else if (leaf) begin
        ev_done        = 1'b1;
        ev_res.found   = 1'b1;
        ev_res.ppn_out = mem_rdata_i[rpt_pkg::PPN_W:1];
      end
    end else if (leaf) begin
      ev_done  = 1'b1;
      ev_we    = 1'b1;
      ev_wdata = item_q.unmap ? '0 : {item_q.new_ppn, 1'b1};
    end else if (!e_valid) begin
      if (item_q.unmap) begin
        ev_done = 1'b1;
      end else if (free_q >= rpt_pkg::FREE_W'(rpt_pkg::NUM_FRAMES)) begin
        ev_done       = 1'b1;
        ev_res.status = 1'b1;
      end else begin
        ev_we    = 1'b1;
        ev_alloc = 1'b1;
        ev_wdata = {rpt_pkg::PPN_W'(free_q), 1'b1};
        ev_frame = free_q[rpt_pkg::FRAME_W-1:0];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpt_pkg::ST_CLEAR: if (clr_last) state_d = rpt_pkg::ST_IDLE;
      rpt_pkg::ST_IDLE:  if (in_acc) state_d = rpt_pkg::ST_READ;
      rpt_pkg::ST_READ:  state_d = rpt_pkg::ST_EVAL;
      rpt_pkg::ST_EVAL:  state_d = ev_done ? rpt_pkg::ST_DONE : rpt_pkg::ST_READ;
      rpt_pkg::ST_DONE:  if (out_free) state_d = rpt_pkg::ST_IDLE;
      default:           state_d = rpt_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and memory requests
  always_comb begin
    clr_d       = clr_q;
    item_d      = item_q;
    level_d     = level_q;
    frame_d     = frame_q;
    addr_d      = addr_q;
    free_d      = free_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_req_o   = '0;
    mem_req_o.waddr = addr_q;
    mem_req_o.raddr = rd_addr;

    if (cfg_i.ff_load) begin
      free_d = rpt_pkg::FREE_W'(cfg_i.ff_value);
    end

    unique case (state_q)
      rpt_pkg::ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        mem_req_o.wdata = '0;
        clr_d           = clr_q + rpt_pkg::ADDR_W'(1);
      end
      rpt_pkg::ST_IDLE: begin
        if (in_acc) begin
          item_d  = in_item_i;
          level_d = '0;
          frame_d = rpt_pkg::FRAME_W'(cfg_i.root_frame);
          res_d   = '0;
        end
      end
      rpt_pkg::ST_READ: begin
        mem_req_o.re = 1'b1;
        addr_d       = rd_addr;
      end
      rpt_pkg::ST_EVAL: begin
        mem_req_o.we    = ev_we;
        mem_req_o.wdata = ev_wdata;
        res_d           = ev_res;
        frame_d         = ev_frame;
        level_d         = level_q + rpt_pkg::LEVEL_W'(1);
        if (ev_alloc) begin
          free_d = free_q + rpt_pkg::FREE_W'(1);
        end
      end
      rpt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpt_pkg::ST_CLEAR;
      clr_q       <= '0;
      free_q      <= rpt_pkg::FREE_W'(rpt_pkg::FIRST_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    level_q <= level_d;
    frame_q <= frame_d;
    addr_q  <= addr_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ rtl/core/radix_page_table_walker.sv @@
// Top level of the radix page table walker: registers, walk sequencer, frame memory.
//
//  channel  direction  handshake                    payload
//  in       in         in_valid_i / in_stall_o      in_item_i  (cmd, vpn, new_ppn, unmap)
//  out      out        out_valid_o / out_stall_i    out_item_o (found, ppn_out, status)
//  config   in         psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// After reset the frame memory is cleared one entry per cycle, all 32768 entries,
// with in_stall_o high throughout; configuration writes are taken meanwhile.
// One item at a time: accept, then per level walked a read state (read issue on
// the single read port) and an evaluate state (evaluate and write back), then a
// done state that loads the output register. A full walk covers five levels.
// A result held by out_stall_i does not block the next item from being taken.
module radix_page_table_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rpt_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rpt_pkg::out_item_t          out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpt_pkg::PADDR_W-1:0] paddr,
  input  logic [rpt_pkg::PDATA_W-1:0] pwdata,
  output logic [rpt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  rpt_pkg::cfg_t               cfg;
  rpt_pkg::mem_req_t           mem_req;
  logic [rpt_pkg::ENTRY_W-1:0] mem_rdata;

  // Configuration registers; a first_free_frame write reloads the allocator
  rpt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Walk sequencer owns both memory ports
  rpt_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Frame memory: one entry per table slot, valid bit in bit 0
  rpt_ram #(
    .WIDTH (rpt_pkg::ENTRY_W),
    .DEPTH (rpt_pkg::DEPTH)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

@@ rtl/core/rpt_checker.sv @@
// Port-level checks for the page table walker, bound to the top level.
module rpt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input rpt_pkg::out_item_t          out_item_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pready
);

  // One item in flight: taking an item closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a walk is running");

  // A hit never carries an abort status
  a_hit_no_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.found |-> !out_item_o.status)
    else $error("hit reported together with abort status");

  // Misses and updates report a zero page
  a_miss_zero_ppn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.ppn_out == '0)
    else $error("nonzero page without a hit");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("access phase without pready");

endmodule

bind radix_page_table_walker rpt_checker u_rpt_checker (.*);

@@ test/rpt_walk_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the radix page table walker: mirrors the tables and checks each result.
module rpt_walk_checker
  import rpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  in_item_t            in_item_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output int                  pending_o,
  output int                  errors_o
);

  localparam int MAX_REPORTS = 200;

  logic [ENTRY_W-1:0] frame_mem [DEPTH];
  int unsigned        alloc_next;
  logic [ROOT_W-1:0]  root_reg;
  out_item_t          walk_results_q [$];

  // Walk the mirrored tables for one item; updates write back into the mirror.
  function automatic out_item_t walk_tables(input in_item_t item);
    out_item_t          res;
    logic [PPN_W-1:0]   frame;
    logic [TABLE_W-1:0] idx;
    logic [ENTRY_W-1:0] entry;
    int                 addr;
    res   = '0;
    frame = PPN_W'(root_reg);
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      idx   = TABLE_W'(item.vpn >> (INDEX_BITS * (LEVELS - 1 - lvl)));
      addr  = int'(frame[FRAME_W-1:0]) * ENTRIES_PER_TABLE + int'(idx);
      entry = frame_mem[addr];
      if (item.cmd == CMD_QUERY) begin
        if (!entry[0]) break;
        if (lvl == LEVELS - 1) begin
          res.found   = 1'b1;
          res.ppn_out = entry[ENTRY_W-1:1];
          break;
        end
      end else if (lvl == LEVELS - 1) begin
        frame_mem[addr] = item.unmap ? '0 : {item.new_ppn, 1'b1};
        break;
      end else if (!entry[0]) begin
        if (item.unmap) break;
        if (alloc_next >= NUM_FRAMES) begin
          res.status = 1'b1;
          break;
        end
        entry           = {PPN_W'(alloc_next), 1'b1};
        frame_mem[addr] = entry;
        alloc_next++;
      end
      frame = entry[ENTRY_W-1:1];
    end
    return res;
  endfunction

  function automatic void note_mismatch(input string field, input logic [PPN_W-1:0] want,
                                        input logic [PPN_W-1:0] got);
    errors_o++;
    if (errors_o <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      for (int a = 0; a < DEPTH; a++) frame_mem[a] = '0;
      root_reg   = ROOT_RESET;
      alloc_next = FIRST_RESET;
      walk_results_q.delete();
      errors_o   = 0;
      pending_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[PADDR_W-1:2]))
          REG_ROOT_FRAME: root_reg   = pwdata[ROOT_W-1:0];
          REG_FIRST_FREE: alloc_next = pwdata[FIRST_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got = out_item_o;
        if (walk_results_q.size() == 0) begin
          errors_o++;
          if (errors_o <= MAX_REPORTS)
            $display("%0t: result with no item pending, got found %0h ppn %0h status %0h",
                     $time, got.found, got.ppn_out, got.status);
        end else begin
          want = walk_results_q.pop_front();
          if (got.found !== want.found)
            note_mismatch("found", PPN_W'(want.found), PPN_W'(got.found));
          if (got.ppn_out !== want.ppn_out)
            note_mismatch("ppn_out", want.ppn_out, got.ppn_out);
          if (got.status !== want.status)
            note_mismatch("status", PPN_W'(want.status), PPN_W'(got.status));
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0)
        walk_results_q.push_back(walk_tables(in_item_i));
      pending_o = walk_results_q.size();
    end
  end

endmodule

@@ test/tb_radix_page_table_walker.sv @@
`timescale 1ns / 100ps
// Testbench top for the radix page table walker: stimulus, idling, pressure and verdict.
module tb_radix_page_table_walker;
  import rpt_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int LONG_HOLD       = 400;
  localparam int HISTORY_DEPTH   = 64;
  localparam int TAIL_CYCLES     = 40;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  logic [PDATA_W-1:0]  pwdata      = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int pending;
  int errors;
  int cycle_count   = 0;
  int idle_pct      = 0;   // chance in a hundred that the sender skips a cycle
  int stall_pct     = 0;   // chance in a hundred that the receiver stalls a cycle
  int hold_requests = 0;   // bumped by the stimulus to ask for one long hold-off
  int holds_served  = 0;
  int hold_left     = 0;

  // Small per-level index palettes so that random mappings share tables and
  // queries land on live paths; the third entry is always an edge index.
  logic [TABLE_W-1:0] vpn_palette [LEVELS][3];
  logic [VPN_W-1:0]   mapped_vpns [$];

  radix_page_table_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  rpt_walk_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stop a hung run; the limit also has to cover the clearing pass.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stall per phase, or a long hold-off counted here
  // whenever the stimulus asks for one.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD - 1;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_item(input cmd_e op, input logic [VPN_W-1:0] vpn,
                           input logic [PPN_W-1:0] ppn, input logic unmap);
    in_item_t item;
    item.cmd     = op;
    item.vpn     = vpn;
    item.new_ppn = ppn;
    item.unmap   = unmap;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Setup cycle, access cycle, then one quiet cycle so back-to-back writes
  // never touch psel twice in one step.
  task automatic config_write(input reg_idx_e which, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({which, 2'b00});
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic new_palette();
    for (int l = 0; l < LEVELS; l++) begin
      vpn_palette[l][0] = TABLE_W'($urandom);
      vpn_palette[l][1] = TABLE_W'($urandom);
      vpn_palette[l][2] = $urandom_range(1) ? '1 : '0;
    end
  endtask

  // Mostly palette indices, now and then a fully random one per level.
  function automatic logic [VPN_W-1:0] random_vpn();
    logic [VPN_W-1:0]   v;
    logic [TABLE_W-1:0] idx;
    v = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if ($urandom_range(9) < 8) idx = vpn_palette[l][$urandom_range(2)];
      else                       idx = TABLE_W'($urandom);
      v = (v << INDEX_BITS) | VPN_W'(idx);
    end
    return v;
  endfunction

  function automatic logic [VPN_W-1:0] known_or_new_vpn();
    if (mapped_vpns.size() > 0 && $urandom_range(4) != 0)
      return mapped_vpns[$urandom_range(mapped_vpns.size() - 1)];
    return random_vpn();
  endfunction

  task automatic send_random_item();
    int               pick;
    logic [VPN_W-1:0] v;
    logic [PPN_W-1:0] ppn;
    pick = $urandom_range(99);
    ppn  = PPN_W'({$urandom, $urandom});
    if (pick < 40) begin
      // map: remember the page so later queries and unmaps can hit it
      v = random_vpn();
      mapped_vpns.push_back(v);
      if (mapped_vpns.size() > HISTORY_DEPTH) void'(mapped_vpns.pop_front());
      send_item(CMD_UPDATE, v, ppn, 1'b0);
    end else if (pick < 75) begin
      send_item(CMD_QUERY, known_or_new_vpn(), ppn, 1'($urandom_range(1)));
    end else if (pick < 88) begin
      send_item(CMD_UPDATE, known_or_new_vpn(), ppn, 1'b1);
    end else if (pick < 93) begin
      send_item(CMD_UPDATE, random_vpn(), ppn, 1'b1);
    end else begin
      send_item(CMD_QUERY, VPN_W'({$urandom, $urandom}), ppn, 1'($urandom_range(1)));
    end
  endtask

  initial begin : stimulus
    logic [VPN_W-1:0] vpn_ones;
    logic [PPN_W-1:0] ppn_ones;
    logic [VPN_W-1:0] vpn_fresh;
    vpn_ones  = '1;
    ppn_ones  = '1;
    vpn_fresh = 45'h1555_5555_5555;
    new_palette();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset register values: empty table, then one path at each
    // edge of the index space. The first item waits out the clearing pass.
    send_item(CMD_QUERY,  '0,       '0,       1'b0);  // miss on an empty table
    send_item(CMD_UPDATE, '0,       '0,       1'b1);  // unmap with a missing path
    send_item(CMD_UPDATE, '0,       '0,       1'b0);  // builds frames 1..4
    send_item(CMD_QUERY,  '0,       ppn_ones, 1'b0);
    send_item(CMD_UPDATE, vpn_ones, ppn_ones, 1'b0);  // builds frames 5..8
    send_item(CMD_QUERY,  vpn_ones, '0,       1'b0);
    send_item(CMD_UPDATE, '0,       ppn_ones, 1'b0);  // overwrite a live leaf
    send_item(CMD_QUERY,  '0,       '0,       1'b1);  // unmap bit ignored on query
    send_item(CMD_UPDATE, '0,       '0,       1'b1);  // clear the leaf
    send_item(CMD_QUERY,  '0,       '0,       1'b0);  // miss at the leaf level
    send_item(CMD_UPDATE, '0,       '0,       1'b1);  // unmap an already empty leaf
    send_item(CMD_QUERY,  45'h1FF,  '0,       1'b0);
    wait_idle();

    // Two frames left: the next fresh path runs dry halfway down.
    config_write(REG_FIRST_FREE, NUM_FRAMES - 2);
    send_item(CMD_UPDATE, vpn_fresh, 52'h123, 1'b0);
    send_item(CMD_QUERY,  vpn_fresh, '0,      1'b0);
    send_item(CMD_UPDATE, vpn_ones,  52'h5,   1'b0);  // existing path needs no frame
    wait_idle();

    // Root on a leaf table: leaf entries are read as table pointers.
    config_write(REG_ROOT_FRAME, 8);
    config_write(REG_FIRST_FREE, NUM_FRAMES);
    send_item(CMD_QUERY,  vpn_ones, '0,       1'b0);
    send_item(CMD_UPDATE, '0,       ppn_ones, 1'b0);  // no frames at all
    wait_idle();

    // Allocator starts at frame 0, which is the root table itself.
    config_write(REG_ROOT_FRAME, 0);
    config_write(REG_FIRST_FREE, 0);
    send_item(CMD_UPDATE, 45'h200,  52'hABC, 1'b0);
    send_item(CMD_QUERY,  45'h200,  '0,      1'b0);
    send_item(CMD_QUERY,  '0,       '0,      1'b0);
    send_item(CMD_QUERY,  vpn_ones, '0,      1'b0);
    wait_idle();

    // Random part: each phase sets both registers, a fresh palette and an
    // idling mode, then drains before the next register writes.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       config_write(REG_ROOT_FRAME, 0);
        1:       config_write(REG_ROOT_FRAME, NUM_FRAMES - 1);
        default: config_write(REG_ROOT_FRAME, $urandom_range(NUM_FRAMES - 1));
      endcase
      case (p % 5)
        0:       config_write(REG_FIRST_FREE, 1);
        1:       config_write(REG_FIRST_FREE, 0);
        2:       config_write(REG_FIRST_FREE, NUM_FRAMES);
        3:       config_write(REG_FIRST_FREE, NUM_FRAMES - 1);
        default: config_write(REG_FIRST_FREE, $urandom_range(NUM_FRAMES));
      endcase
      new_palette();
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 60; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 60; end
        default: begin idle_pct = 13; stall_pct <= 13; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Long hold-off on the result side while items keep coming with no
        // gaps, so the walker fills up and stalls its input.
        if ((p == 4 || p == 8) && n == 20) hold_requests <= hold_requests + 1;
        send_random_item();
      end
      wait_idle();
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rpt_pkg.sv
rtl/core/rpt_ram.sv
rtl/core/rpt_regs.sv
rtl/core/rpt_walk.sv
rtl/core/radix_page_table_walker.sv
rtl/core/rpt_checker.sv
test/rpt_walk_checker.sv
test/tb_radix_page_table_walker.sv
